// ----- src/ppmrc_pkg.sv -----
// Package for the PPM radio-control frame decoder.
// Holds shared constants, register and mode codes, and the scaler status type.
// No dependencies.
package ppmrc_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_W     = $clog2(CHANNELS);
	localparam int SLOT_W   = $clog2(CHANNELS + 1);

	localparam int PW_W     = 16;
	localparam int VAL_W    = 14;
	localparam int ALERT_W  = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam int FULL_SCALE        = 10000;
	localparam int SWITCH_LEVEL      = 8000;
	localparam int FAILSAFE_THROTTLE = 2000;
	localparam int ARM_CH = 4;
	localparam int AUX_CH = 6;
	localparam int THR_CH = 1;

	// divider geometry: quotient below FULL_SCALE fits VAL_W bits, two bits per cycle
	localparam int PROD_W    = PW_W + VAL_W;
	localparam int DIV_STEPS = VAL_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [1:0] MODE_CAPTURE = 2'd0;
	localparam logic [1:0] MODE_OVERRUN = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_ENABLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALERT_PERIOD = 2'd3;

	localparam int TDATA_W = 24;

	typedef struct packed {
		logic             done;
		logic [VAL_W-1:0] value;
	} scl_stat_t;

endpackage

// ----- src/ppmrc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module ppmrc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- src/ppmrc_scaler.sv -----
// Pulse width scaler: (width - min) * 10000 / (max - min), truncated and clamped.
// Constant multiply stage, then a two-bit-per-cycle restoring divider.
// Depends on ppmrc_pkg.
module ppmrc_scaler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ppmrc_pkg::PW_W-1:0]  width,
	input  logic [ppmrc_pkg::PW_W-1:0]  min_width,
	input  logic [ppmrc_pkg::PW_W-1:0]  max_width,
	output ppmrc_pkg::scl_stat_t        stat
);

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_MUL,
		SC_DIV
	} sc_state_t;

	sc_state_t                          state_q;
	logic [ppmrc_pkg::PW_W:0]           diff;
	logic [ppmrc_pkg::PW_W:0]           span;
	logic [ppmrc_pkg::PW_W:0]           diff_neg;
	logic [ppmrc_pkg::PW_W:0]           span_neg;
	logic [ppmrc_pkg::PW_W-1:0]         abs_diff;
	logic [ppmrc_pkg::PW_W-1:0]         abs_span;
	logic [ppmrc_pkg::PW_W-1:0]         num_q;
	logic [ppmrc_pkg::PW_W-1:0]         den_q;
	logic [ppmrc_pkg::PROD_W-1:0]       prod;
	logic [ppmrc_pkg::PW_W-1:0]         rem_q;
	logic [ppmrc_pkg::VAL_W-1:0]        quo_q;
	logic [ppmrc_pkg::STEP_W-1:0]       step_q;
	logic [ppmrc_pkg::PW_W:0]           r1;
	logic [ppmrc_pkg::PW_W:0]           r2;
	logic                               ge1;
	logic                               ge2;
	logic [ppmrc_pkg::PW_W-1:0]         r1n;
	logic [ppmrc_pkg::PW_W-1:0]         r2n;
	logic [ppmrc_pkg::VAL_W-1:0]        q1;
	logic [ppmrc_pkg::VAL_W-1:0]        quo_n;
	logic                               done_q;
	logic [ppmrc_pkg::VAL_W-1:0]        value_q;

	always_comb begin
		diff     = {1'b0, width} - {1'b0, min_width};
		span     = {1'b0, max_width} - {1'b0, min_width};
		diff_neg = -diff;
		span_neg = -span;
		abs_diff = diff[ppmrc_pkg::PW_W] ? diff_neg[ppmrc_pkg::PW_W-1:0]
		                                 : diff[ppmrc_pkg::PW_W-1:0];
		abs_span = span[ppmrc_pkg::PW_W] ? span_neg[ppmrc_pkg::PW_W-1:0]
		                                 : span[ppmrc_pkg::PW_W-1:0];
	end

	assign prod = ppmrc_pkg::PROD_W'(num_q) * ppmrc_pkg::PROD_W'(ppmrc_pkg::FULL_SCALE);

	always_comb begin
		r1    = {rem_q, quo_q[ppmrc_pkg::VAL_W-1]};
		ge1   = r1 >= {1'b0, den_q};
		r1n   = ge1 ? ppmrc_pkg::PW_W'(r1 - {1'b0, den_q}) : r1[ppmrc_pkg::PW_W-1:0];
		q1    = {quo_q[ppmrc_pkg::VAL_W-2:0], ge1};
		r2    = {r1n, q1[ppmrc_pkg::VAL_W-1]};
		ge2   = r2 >= {1'b0, den_q};
		r2n   = ge2 ? ppmrc_pkg::PW_W'(r2 - {1'b0, den_q}) : r2[ppmrc_pkg::PW_W-1:0];
		quo_n = {q1[ppmrc_pkg::VAL_W-2:0], ge2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				SC_IDLE: begin
					if (start) begin
						// zero or opposite signs give zero; ratio of one or more clamps to full
						if (diff == '0 || (diff[ppmrc_pkg::PW_W] ^ span[ppmrc_pkg::PW_W])) begin
							value_q <= '0;
							done_q  <= 1'b1;
						end else if (abs_diff >= abs_span) begin
							value_q <= ppmrc_pkg::VAL_W'(ppmrc_pkg::FULL_SCALE);
							done_q  <= 1'b1;
						end else begin
							num_q   <= abs_diff;
							den_q   <= abs_span;
							done_q  <= 1'b0;
							state_q <= SC_MUL;
						end
					end else begin
						done_q <= 1'b0;
					end
				end
				SC_MUL: begin
					rem_q   <= prod[ppmrc_pkg::PROD_W-1:ppmrc_pkg::VAL_W];
					quo_q   <= prod[ppmrc_pkg::VAL_W-1:0];
					step_q  <= '0;
					done_q  <= 1'b0;
					state_q <= SC_DIV;
				end
				SC_DIV: begin
					rem_q  <= r2n;
					quo_q  <= quo_n;
					step_q <= step_q + 1'b1;
					if (step_q == ppmrc_pkg::STEP_W'(ppmrc_pkg::DIV_STEPS - 1)) begin
						value_q <= quo_n;
						done_q  <= 1'b1;
						state_q <= SC_IDLE;
					end else begin
						done_q <= 1'b0;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign stat.done  = done_q;
	assign stat.value = value_q;

endmodule

// ----- src/ppm_rc_frame_decoder.sv -----
// Top level of the 8-channel PPM radio-control frame decoder.
// Depends on ppmrc_pkg, ppmrc_ram and ppmrc_scaler.
//
// Input stream: tuser carries the mode (capture, overrun, tick), tdata the
// captured pulse width. Config port: cfg_wr_en writes cfg_wdata to register
// cfg_index (min width, max width, alert enable, alert period); the user must
// write it only while idle, the block does not enforce it. Output stream: one
// transaction per channel on a tick with signal, tlast on channel 7; one failsafe
// transaction on a tick without signal. Captures and overruns are taken in idle.
// A valid tick reads both stores, then runs each channel through the shared
// scaler (clamped results skip the divider, divided ones take one multiply and
// seven two-bit divider steps), writes back the average, then reads the filtered
// store again to emit. A failsafe tick reads the throttle entry, then emits.
// Pulse and filtered stores are 8-entry RAMs with registered read; per-entry
// valid flags cleared by reset make both read as zero until written, so the
// block is ready right after reset. A stalled receiver holds the output
// register and the sequencer waits; captures are still taken while idle.
module ppm_rc_frame_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [ppmrc_pkg::PW_W-1:0]          s_axis_tdata,  // [15:0] pulse_width
	input  logic [1:0]                          s_axis_tuser,  // [1:0] mode
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [2:0] channel, [16:3] value, [17] arm_switch, [18] aux_switch,
	// [19] alert_pulse, [23:20] zero
	output logic [ppmrc_pkg::TDATA_W-1:0]       m_axis_tdata,
	output logic                                m_axis_tuser,  // [0] receiver_ok
	output logic                                m_axis_tlast,
	input  logic                                cfg_wr_en,
	input  logic [ppmrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ppmrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CRD,
		S_CST,
		S_CWT,
		S_ERD,
		S_EOUT,
		S_FRD,
		S_FOUT
	} state_t;

	localparam int CH_W  = ppmrc_pkg::CH_W;
	localparam int VAL_W = ppmrc_pkg::VAL_W;

	state_t                             state_q;
	logic [CH_W-1:0]                    ch_q;
	logic [ppmrc_pkg::SLOT_W-1:0]       slot_q;
	logic                               missing_q;
	logic                               seen_q;
	logic [ppmrc_pkg::ALERT_W-1:0]      alert_cnt_q;
	logic [ppmrc_pkg::PW_W-1:0]         min_q;
	logic [ppmrc_pkg::PW_W-1:0]         max_q;
	logic                               alert_en_q;
	logic [ppmrc_pkg::ALERT_W-1:0]      period_q;
	logic [ppmrc_pkg::CHANNELS-1:0]     pulse_vld_q;
	logic [ppmrc_pkg::CHANNELS-1:0]     filt_vld_q;
	logic [VAL_W-1:0]                   old_q;
	logic                               arm_q;
	logic                               aux_q;
	logic                               m_valid_q;
	logic [ppmrc_pkg::TDATA_W-1:0]      m_data_q;
	logic                               m_user_q;
	logic                               m_last_q;

	logic                               in_fire;
	logic                               out_free;
	logic                               out_load;
	logic                               ch_last;
	logic                               pulse_we;
	logic [CH_W-1:0]                    pulse_waddr;
	logic                               pulse_re;
	logic [ppmrc_pkg::PW_W-1:0]         pulse_rdata;
	logic [ppmrc_pkg::PW_W-1:0]         pulse_val;
	logic                               filt_we;
	logic                               filt_re;
	logic [CH_W-1:0]                    filt_raddr;
	logic [VAL_W-1:0]                   filt_rdata;
	logic [VAL_W-1:0]                   filt_val;
	logic [VAL_W:0]                     avg_sum;
	logic [VAL_W-1:0]                   avg_val;
	logic [VAL_W-1:0]                   thr_val;
	logic                               scl_start;
	ppmrc_pkg::scl_stat_t               scl_stat;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign out_load      = ((state_q == S_EOUT) || (state_q == S_FOUT)) && out_free;
	assign ch_last       = (ch_q == CH_W'(ppmrc_pkg::CHANNELS - 1));

	assign pulse_we    = in_fire && (s_axis_tuser == ppmrc_pkg::MODE_CAPTURE)
	                     && (slot_q < ppmrc_pkg::SLOT_W'(ppmrc_pkg::CHANNELS));
	assign pulse_waddr = slot_q[CH_W-1:0];
	assign pulse_re    = (state_q == S_CRD);
	assign filt_re     = (state_q == S_CRD) || (state_q == S_ERD) || (state_q == S_FRD);
	assign filt_raddr  = ((state_q == S_FRD) || (state_q == S_FOUT))
	                     ? CH_W'(ppmrc_pkg::THR_CH) : ch_q;
	assign filt_we     = (state_q == S_CWT) && scl_stat.done;
	assign scl_start   = (state_q == S_CST);

	assign pulse_val = pulse_vld_q[ch_q] ? pulse_rdata : '0;
	assign filt_val  = filt_vld_q[filt_raddr] ? filt_rdata : '0;
	assign avg_sum   = {1'b0, old_q} + {1'b0, scl_stat.value};
	assign avg_val   = avg_sum[VAL_W:1];
	assign thr_val   = (filt_val > VAL_W'(ppmrc_pkg::FAILSAFE_THROTTLE))
	                   ? VAL_W'(ppmrc_pkg::FAILSAFE_THROTTLE) : filt_val;

	ppmrc_ram #(
		.WIDTH (ppmrc_pkg::PW_W),
		.DEPTH (ppmrc_pkg::CHANNELS)
	) u_pulse_ram (
		.clk   (clk),
		.we    (pulse_we),
		.waddr (pulse_waddr),
		.wdata (s_axis_tdata),
		.re    (pulse_re),
		.raddr (ch_q),
		.rdata (pulse_rdata)
	);

	ppmrc_ram #(
		.WIDTH (VAL_W),
		.DEPTH (ppmrc_pkg::CHANNELS)
	) u_filt_ram (
		.clk   (clk),
		.we    (filt_we),
		.waddr (ch_q),
		.wdata (avg_val),
		.re    (filt_re),
		.raddr (filt_raddr),
		.rdata (filt_rdata)
	);

	ppmrc_scaler u_scaler (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scl_start),
		.width     (pulse_val),
		.min_width (min_q),
		.max_width (max_q),
		.stat      (scl_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q      <= ppmrc_pkg::PW_W'(1000);
			max_q      <= ppmrc_pkg::PW_W'(2000);
			alert_en_q <= 1'b0;
			period_q   <= ppmrc_pkg::ALERT_W'(4000);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				ppmrc_pkg::REG_MIN_WIDTH:    min_q      <= cfg_wdata[ppmrc_pkg::PW_W-1:0];
				ppmrc_pkg::REG_MAX_WIDTH:    max_q      <= cfg_wdata[ppmrc_pkg::PW_W-1:0];
				ppmrc_pkg::REG_ALERT_ENABLE: alert_en_q <= cfg_wdata[0];
				ppmrc_pkg::REG_ALERT_PERIOD: period_q   <= cfg_wdata[ppmrc_pkg::ALERT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			slot_q      <= '0;
			missing_q   <= 1'b1;
			seen_q      <= 1'b0;
			alert_cnt_q <= '0;
			pulse_vld_q <= '0;
			filt_vld_q  <= '0;
			arm_q       <= 1'b0;
			aux_q       <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (m_valid_q && m_axis_tready && !out_load) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						unique case (s_axis_tuser)
							ppmrc_pkg::MODE_CAPTURE: begin
								if (slot_q >= ppmrc_pkg::SLOT_W'(ppmrc_pkg::CHANNELS)) begin
									slot_q <= '0;
								end else begin
									pulse_vld_q[pulse_waddr] <= 1'b1;
									slot_q <= slot_q + 1'b1;
									if (slot_q == ppmrc_pkg::SLOT_W'(ppmrc_pkg::CHANNELS - 1)) begin
										missing_q <= 1'b0;
									end
								end
							end
							ppmrc_pkg::MODE_OVERRUN: begin
								if (slot_q != ppmrc_pkg::SLOT_W'(ppmrc_pkg::CHANNELS)) begin
									missing_q <= 1'b1;
									slot_q    <= ppmrc_pkg::SLOT_W'(ppmrc_pkg::CHANNELS);
								end
							end
							ppmrc_pkg::MODE_TICK: begin
								ch_q    <= '0;
								state_q <= missing_q ? S_FRD : S_CRD;
							end
							default: ;
						endcase
					end
				end
				S_CRD: state_q <= S_CST;
				S_CST: begin
					old_q   <= filt_val;
					state_q <= S_CWT;
				end
				S_CWT: begin
					if (scl_stat.done) begin
						filt_vld_q[ch_q] <= 1'b1;
						if (ch_q == CH_W'(ppmrc_pkg::ARM_CH)) begin
							arm_q <= avg_val > VAL_W'(ppmrc_pkg::SWITCH_LEVEL);
						end
						if (ch_q == CH_W'(ppmrc_pkg::AUX_CH)) begin
							aux_q <= avg_val > VAL_W'(ppmrc_pkg::SWITCH_LEVEL);
						end
						if (ch_last) begin
							ch_q    <= '0;
							state_q <= S_ERD;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_CRD;
						end
					end
				end
				S_ERD: state_q <= S_EOUT;
				S_EOUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {4'd0, 1'b0, aux_q, arm_q, filt_val, 3'(ch_q)};
						m_user_q  <= 1'b1;
						m_last_q  <= ch_last;
						if (ch_last) begin
							seen_q      <= 1'b1;
							alert_cnt_q <= '0;
							state_q     <= S_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				S_FRD: state_q <= S_FOUT;
				S_FOUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_user_q  <= 1'b0;
						m_last_q  <= 1'b1;
						m_data_q  <= {4'd0, seen_q && alert_en_q && (alert_cnt_q == period_q),
						              1'b0, 1'b0, thr_val, 3'(ppmrc_pkg::THR_CH)};
						if (seen_q && alert_en_q) begin
							if (alert_cnt_q == period_q) begin
								alert_cnt_q <= '0;
							end else begin
								alert_cnt_q <= alert_cnt_q + 1'b1;
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		scl_stat.done |-> scl_stat.value <= VAL_W'(ppmrc_pkg::FULL_SCALE))
		else $error("scaler result above full scale");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			m_axis_tlast && m_axis_tdata[2:0] == 3'(ppmrc_pkg::THR_CH)
			&& m_axis_tdata[16:3] <= VAL_W'(ppmrc_pkg::FAILSAFE_THROTTLE))
		else $error("failsafe transaction malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tlast == (m_axis_tdata[2:0] == 3'(ppmrc_pkg::CHANNELS - 1)))
		else $error("tlast not on final channel");

	assert property (@(posedge clk) disable iff (!arst_n)
		filt_we |-> state_q == S_CWT && avg_val <= VAL_W'(ppmrc_pkg::FULL_SCALE))
		else $error("filtered store write out of range");

endmodule
